// ----- design/cdc_pkg.sv -----
`default_nettype none
package cdc_pkg;

  localparam int unsigned MV_W    = 13;
  localparam int unsigned CYCLE_W = 16;

  localparam logic [MV_W-1:0]    CHARGE_CUTOFF_RESET    = MV_W'(4200);
  localparam logic [MV_W-1:0]    DISCHARGE_CUTOFF_RESET = MV_W'(3000);
  localparam logic [CYCLE_W-1:0] CYCLE_MAX              = '1;

  typedef enum logic [2:0] {
    OP_KEY1_CLICK = 3'd0,
    OP_KEY1_LONG  = 3'd1,
    OP_KEY2_CLICK = 3'd2,
    OP_KEY2_LONG  = 3'd3,
    OP_SAMPLE     = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    RUN_STOP            = 3'd0,
    RUN_CHARGE          = 3'd1,
    RUN_CHARGE_PAUSE    = 3'd2,
    RUN_DISCHARGE       = 3'd3,
    RUN_DISCHARGE_PAUSE = 3'd4
  } run_state_t;

  typedef enum logic [1:0] {
    PHASE_REST      = 2'd0,
    PHASE_CHARGE    = 2'd1,
    PHASE_DISCHARGE = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    EV_NONE   = 4'd0,
    EV_START  = 4'd1,
    EV_PAUSE  = 4'd2,
    EV_RESUME = 4'd3,
    EV_STOP   = 4'd4,
    EV_GEAR   = 4'd5,
    EV_MODE   = 4'd6,
    EV_FULL   = 4'd7,
    EV_EMPTY  = 4'd8
  } event_t;

  typedef enum logic {
    WORK_CHARGE    = 1'b0,
    WORK_DISCHARGE = 1'b1
  } mode_t;

  typedef enum logic {
    CFG_CHARGE_CUTOFF    = 1'b0,
    CFG_DISCHARGE_CUTOFF = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic               discharge_gear_sel;
    logic               charge_gear_sel;
    logic [CYCLE_W-1:0] cycle_total;
    event_t             event_code;
    phase_t             phase_kind;
    mode_t              work_mode;
    run_state_t         run_state;
    logic               discharge_high_current;
    logic               charge_high_current;
    logic               discharge_enable;
    logic               charge_enable;
  } result_t;

endpackage
`default_nettype wire

// ----- design/cdc_core.sv -----
`default_nettype none
module cdc_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     step,
  input  wire cdc_pkg::op_t             op,
  input  wire logic [cdc_pkg::MV_W-1:0] mv,
  input  wire logic                     cfg_write,
  input  wire cdc_pkg::cfg_index_t      cfg_index,
  input  wire logic [cdc_pkg::MV_W-1:0] cfg_data,
  output cdc_pkg::result_t              result
);
  import cdc_pkg::*;

  logic [MV_W-1:0]    charge_cutoff;
  logic [MV_W-1:0]    discharge_cutoff;
  run_state_t         run, run_next;
  mode_t              mode, mode_next;
  logic               charge_gear, charge_gear_next;
  logic               discharge_gear, discharge_gear_next;
  logic               charge_pin, charge_pin_next;
  logic               discharge_pin, discharge_pin_next;
  logic [CYCLE_W-1:0] cycle, cycle_next;
  event_t             ev, ev_next;
  logic               drive;
  phase_t             phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_cutoff    <= CHARGE_CUTOFF_RESET;
      discharge_cutoff <= DISCHARGE_CUTOFF_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CHARGE_CUTOFF:    charge_cutoff    <= cfg_data;
        CFG_DISCHARGE_CUTOFF: discharge_cutoff <= cfg_data;
        default:              ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run            <= RUN_STOP;
      mode           <= WORK_CHARGE;
      charge_gear    <= 1'b0;
      discharge_gear <= 1'b0;
      charge_pin     <= 1'b0;
      discharge_pin  <= 1'b0;
      cycle          <= '0;
      ev             <= EV_NONE;
    end else if (step) begin
      run            <= run_next;
      mode           <= mode_next;
      charge_gear    <= charge_gear_next;
      discharge_gear <= discharge_gear_next;
      charge_pin     <= charge_pin_next;
      discharge_pin  <= discharge_pin_next;
      cycle          <= cycle_next;
      ev             <= ev_next;
    end
  end

  always_comb begin
    run_next            = run;
    mode_next           = mode;
    charge_gear_next    = charge_gear;
    discharge_gear_next = discharge_gear;
    cycle_next          = cycle;
    ev_next             = ev;
    drive               = 1'b0;
    case (op)
      OP_KEY1_CLICK: begin
        drive = 1'b1;
        unique case (run)
          RUN_STOP: begin
            run_next = (mode == WORK_DISCHARGE) ? RUN_DISCHARGE : RUN_CHARGE;
            if (cycle != CYCLE_MAX) begin
              cycle_next = cycle + CYCLE_W'(1);
            end
            ev_next = EV_START;
          end
          RUN_CHARGE: begin
            run_next = RUN_CHARGE_PAUSE;
            ev_next  = EV_PAUSE;
          end
          RUN_CHARGE_PAUSE: begin
            run_next = RUN_CHARGE;
            ev_next  = EV_RESUME;
          end
          RUN_DISCHARGE: begin
            run_next = RUN_DISCHARGE_PAUSE;
            ev_next  = EV_PAUSE;
          end
          RUN_DISCHARGE_PAUSE: begin
            run_next = RUN_DISCHARGE;
            ev_next  = EV_RESUME;
          end
          default: run_next = RUN_STOP;
        endcase
      end
      OP_KEY1_LONG: begin
        if (run != RUN_STOP) begin
          run_next = RUN_STOP;
          ev_next  = EV_STOP;
        end
      end
      OP_KEY2_CLICK: begin
        drive = 1'b1;
        if (mode == WORK_CHARGE) begin
          charge_gear_next = ~charge_gear;
        end else begin
          discharge_gear_next = ~discharge_gear;
        end
        ev_next = EV_GEAR;
      end
      OP_KEY2_LONG: begin
        if (run == RUN_STOP) begin
          mode_next = (mode == WORK_CHARGE) ? WORK_DISCHARGE : WORK_CHARGE;
          ev_next   = EV_MODE;
        end
      end
      OP_SAMPLE: begin
        if (run == RUN_CHARGE && mv >= charge_cutoff) begin
          run_next = RUN_STOP;
          ev_next  = EV_FULL;
        end else if (run == RUN_DISCHARGE && mv <= discharge_cutoff) begin
          run_next = RUN_STOP;
          ev_next  = EV_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // The running side re-latches its gear pin after a key 1 or key 2 click.
  always_comb begin
    charge_pin_next    = charge_pin;
    discharge_pin_next = discharge_pin;
    if (drive && run_next == RUN_CHARGE) begin
      charge_pin_next = charge_gear_next;
    end else if (drive && run_next == RUN_DISCHARGE) begin
      discharge_pin_next = discharge_gear_next;
    end
  end

  always_comb begin
    case (run_next) inside
      RUN_CHARGE, RUN_CHARGE_PAUSE:       phase = PHASE_CHARGE;
      RUN_DISCHARGE, RUN_DISCHARGE_PAUSE: phase = PHASE_DISCHARGE;
      default:                            phase = PHASE_REST;
    endcase
  end

  always_comb begin
    result.charge_enable          = (run_next == RUN_CHARGE);
    result.discharge_enable       = (run_next == RUN_DISCHARGE);
    result.charge_high_current    = charge_pin_next;
    result.discharge_high_current = discharge_pin_next;
    result.run_state              = run_next;
    result.work_mode              = mode_next;
    result.phase_kind             = phase;
    result.event_code             = ev_next;
    result.cycle_total            = cycle_next;
    result.charge_gear_sel        = charge_gear_next;
    result.discharge_gear_sel     = discharge_gear_next;
  end

endmodule
`default_nettype wire

// ----- design/charge_discharge_controller_top.sv -----
`default_nettype none
// Each input beat is held in the input register, its result in the result register.
// Throughput: one beat per cycle unless m_tready holds the output; the controller
// update between the two registers is combinational compare and select logic.
// Reset (synchronous, active high) stops the controller, selects charge mode and
// gear one, clears pin latches, the cycle count and the last event, and sets the
// cutoffs to 4200 mV and 3000 mV.
module charge_discharge_controller_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [12:0] voltage_mv, [15:13] zero
  input  wire logic [2:0]  s_tuser,   // [2:0] operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] charge_enable, [1] discharge_enable, [2] charge_high_current,
  // [3] discharge_high_current, [6:4] run_state, [7] work_mode, [9:8] phase_kind,
  // [13:10] event_code, [29:14] cycle_total, [30] charge_gear_sel,
  // [31] discharge_gear_sel
  output logic [31:0]      m_tdata,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);
  import cdc_pkg::*;

  logic            in_valid;
  op_t             in_op;
  logic [MV_W-1:0] in_mv;
  logic            advance;
  result_t         core_result;
  result_t         res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op <= op_t'(s_tuser);
      in_mv <= s_tdata[MV_W-1:0];
    end
  end

  cdc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .op        (in_op),
    .mv        (in_mv),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_result;
    end
  end

  assign m_tdata = {res.discharge_gear_sel, res.charge_gear_sel, res.cycle_total,
                    res.event_code, res.phase_kind, res.work_mode, res.run_state,
                    res.discharge_high_current, res.charge_high_current,
                    res.discharge_enable, res.charge_enable};

`ifndef SYNTHESIS
  a_enables_interlocked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.charge_enable && res.discharge_enable))
    else $error("charge and discharge enables both high");

  a_enable_matches_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res.charge_enable == (res.run_state == RUN_CHARGE)) &&
                  (res.discharge_enable == (res.run_state == RUN_DISCHARGE))))
    else $error("enable outputs disagree with run state");

  a_phase_matches_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res.phase_kind == PHASE_REST) == (res.run_state == RUN_STOP)))
    else $error("phase disagrees with run state");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stage empty but not ready");
`endif

endmodule
`default_nettype wire
